>>> rtl/c2d_pkg.sv
// Shared types and constants for the streaming 4x4 convolution core.
package c2d_pkg;

   localparam int KSIZE      = 4;
   localparam int LINES      = KSIZE - 1;
   localparam int PIX_W      = 8;
   localparam int COEF_W     = 16;
   localparam int KREG_W     = KSIZE * COEF_W;
   localparam int KREG_IDX_W = 2;
   localparam int SUM_W      = 28;
   localparam int IDX_W      = 5;
   localparam int PROD_W     = 24;
   localparam int PSUM_W     = 26;
   localparam int QDEPTH     = 4;
   localparam int QPTR_W     = $clog2(QDEPTH);
   localparam int QCNT_W     = $clog2(QDEPTH + 1);

   typedef logic [KSIZE-1:0][KREG_W-1:0] kernel_type;
   typedef logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] window_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
   } req_payload_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] conv_sum;
      logic [IDX_W-1:0]        out_row;
      logic [IDX_W-1:0]        out_col;
      logic                    last_of_image;
   } rsp_payload_type;

   // One full window handed from the front end to the arithmetic back end.
   typedef struct packed {
      window_type       win;
      logic [IDX_W-1:0] out_row;
      logic [IDX_W-1:0] out_col;
      logic             last_of_image;
   } win_item_type;

   typedef struct packed {
      logic         push;
      win_item_type item;
   } q_push_type;

   typedef struct packed {
      logic              not_empty;
      logic [QCNT_W-1:0] count;
   } q_status_type;

endpackage

>>> rtl/c2d_stream_if.sv
// Valid/ready stream channel carrying one payload per request.
interface c2d_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/c2d_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module c2d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/c2d_front.sv
// Front end: accepts pixels, keeps the line buffers and the window, emits full windows.
module c2d_front #(
   parameter int IMG_SIZE = 28
) (
   input  logic                   clock,
   input  logic                   reset,
   c2d_stream_if.sink             req_chan,
   input  c2d_pkg::q_status_type  q_status,
   output c2d_pkg::q_push_type    q_push
);
   import c2d_pkg::*;

   localparam int CNT_W   = $clog2(IMG_SIZE);
   localparam int IDX_EXT = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam int LINE_W  = LINES * PIX_W;

   logic [CNT_W-1:0] row_count_ff, row_count_in;
   logic [CNT_W-1:0] col_count_ff, col_count_in;
   logic             s1_valid_ff;
   logic [PIX_W-1:0] s1_pixel_ff;
   logic [CNT_W-1:0] s1_row_ff;
   logic [CNT_W-1:0] s1_col_ff;
   window_type       win_ff, win_in;
   logic             accept;
   logic [LINE_W-1:0] line_rd;
   logic [LINE_W-1:0] line_wr;
   logic [KSIZE-1:0][PIX_W-1:0] column;
   logic [IDX_EXT-1:0] row_ext;
   logic [IDX_EXT-1:0] col_ext;

   // Room is reserved for the request in the register stage as well as the queue.
   assign req_chan.ready = (q_status.count + QCNT_W'(s1_valid_ff)) < QCNT_W'(QDEPTH);
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (accept) begin
         if (col_count_ff == CNT_W'(IMG_SIZE - 1)) begin
            col_count_in = '0;
            if (row_count_ff == CNT_W'(IMG_SIZE - 1)) begin
               row_count_in = '0;
            end else begin
               row_count_in = row_count_ff + 1'b1;
            end
         end else begin
            col_count_in = col_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= '0;
         col_count_ff <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         s1_valid_ff  <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_chan.payload.pixel;
         s1_row_ff   <= row_count_ff;
         s1_col_ff   <= col_count_ff;
      end
      win_ff <= win_in;
   end

   // Each RAM word holds one column of the three buffered rows, oldest row in the low byte.
   // The read address is the column of the next request, so the data lines up with stage one.
   c2d_ram #(
      .WIDTH (LINE_W),
      .DEPTH (IMG_SIZE)
   ) u_c2d_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (line_wr),
      .rd_addr (col_count_ff),
      .rd_data (line_rd)
   );

   always_comb begin
      for (int m = 0; m < LINES; m++) begin
         column[m] = line_rd[m*PIX_W +: PIX_W];
      end
      column[LINES] = s1_pixel_ff;
      line_wr = {s1_pixel_ff, line_rd[LINE_W-1:PIX_W]};

      win_in = win_ff;
      if (s1_valid_ff) begin
         for (int m = 0; m < KSIZE; m++) begin
            for (int n = 0; n < KSIZE - 1; n++) begin
               win_in[m][n] = win_ff[m][n+1];
            end
            win_in[m][KSIZE-1] = column[m];
         end
      end
   end

   always_comb begin
      row_ext = IDX_EXT'(s1_row_ff) - IDX_EXT'(LINES);
      col_ext = IDX_EXT'(s1_col_ff) - IDX_EXT'(LINES);
      q_push.push = s1_valid_ff && (s1_row_ff >= CNT_W'(LINES))
                    && (s1_col_ff >= CNT_W'(LINES));
      q_push.item.win     = win_in;
      q_push.item.out_row = row_ext[IDX_W-1:0];
      q_push.item.out_col = col_ext[IDX_W-1:0];
      q_push.item.last_of_image = (s1_row_ff == CNT_W'(IMG_SIZE - 1))
                                  && (s1_col_ff == CNT_W'(IMG_SIZE - 1));
   end
endmodule

>>> rtl/c2d_queue.sv
// Short FIFO of complete windows between the front end and the back end.
module c2d_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  c2d_pkg::q_push_type   q_push,
   input  logic                  pop,
   output c2d_pkg::win_item_type head,
   output c2d_pkg::q_status_type q_status
);
   import c2d_pkg::*;

   win_item_type      store_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = q_push.push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(q_push.push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.push) begin
         store_ff[wr_ptr_ff] <= q_push.item;
      end
   end

   assign head               = store_ff[rd_ptr_ff];
   assign q_status.count     = count_ff;
   assign q_status.not_empty = (count_ff != '0);
endmodule

>>> rtl/c2d_back.sv
// Back end: multiplies the window by the kernel and sums the products over two stages.
module c2d_back (
   input  logic                  clock,
   input  logic                  reset,
   input  c2d_pkg::kernel_type   kernel,
   input  c2d_pkg::win_item_type head,
   input  c2d_pkg::q_status_type q_status,
   output logic                  pop,
   c2d_stream_if.source          rsp_chan
);
   import c2d_pkg::*;

   localparam int TAPS = KSIZE * KSIZE;

   logic                      enable;
   logic                      a_valid_ff;
   logic signed [PROD_W-1:0]  a_prod_ff [TAPS];
   logic signed [PROD_W-1:0]  a_prod_in [TAPS];
   logic [IDX_W-1:0]          a_row_ff, a_col_ff;
   logic                      a_last_ff;
   logic                      b_valid_ff;
   logic signed [PSUM_W-1:0]  b_psum_ff [KSIZE];
   logic signed [PSUM_W-1:0]  b_psum_in [KSIZE];
   logic [IDX_W-1:0]          b_row_ff, b_col_ff;
   logic                      b_last_ff;
   logic                      out_valid_ff;
   rsp_payload_type           out_ff, out_in;

   // The whole pipeline moves whenever the output register is free or being taken.
   assign enable = !out_valid_ff || rsp_chan.ready;
   assign pop    = enable && q_status.not_empty;

   always_comb begin
      logic signed [PIX_W:0]          px_s;
      logic signed [COEF_W-1:0]       cf;
      logic signed [PIX_W+COEF_W-1:0] full;
      px_s = '0;
      cf   = '0;
      full = '0;
      for (int m = 0; m < KSIZE; m++) begin
         for (int n = 0; n < KSIZE; n++) begin
            px_s = signed'({1'b0, head.win[m][n]});
            cf   = signed'(kernel[m][n*COEF_W +: COEF_W]);
            full = px_s * cf;
            a_prod_in[m*KSIZE+n] = full[PROD_W-1:0];
         end
      end
   end

   always_comb begin
      for (int g = 0; g < KSIZE; g++) begin
         b_psum_in[g] = PSUM_W'(a_prod_ff[g*KSIZE]) + PSUM_W'(a_prod_ff[g*KSIZE+1])
                      + PSUM_W'(a_prod_ff[g*KSIZE+2]) + PSUM_W'(a_prod_ff[g*KSIZE+3]);
      end
      out_in.conv_sum = SUM_W'(b_psum_ff[0]) + SUM_W'(b_psum_ff[1])
                      + SUM_W'(b_psum_ff[2]) + SUM_W'(b_psum_ff[3]);
      out_in.out_row       = b_row_ff;
      out_in.out_col       = b_col_ff;
      out_in.last_of_image = b_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         a_valid_ff   <= q_status.not_empty;
         b_valid_ff   <= a_valid_ff;
         out_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_prod_ff <= a_prod_in;
         a_row_ff  <= head.out_row;
         a_col_ff  <= head.out_col;
         a_last_ff <= head.last_of_image;
         b_psum_ff <= b_psum_in;
         b_row_ff  <= a_row_ff;
         b_col_ff  <= a_col_ff;
         b_last_ff <= a_last_ff;
         out_ff    <= out_in;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;
endmodule

>>> rtl/conv2d_4x4_valid_stream_core.sv
// Top level of the streaming 4x4 valid-mode convolution: kernel registers and the three stages.
//
//   Channel   Direction  Handshake           Contents
//   req_chan  in         valid/ready         pixel, row-major, 8-bit unsigned
//   rsp_chan  out        valid/ready         conv_sum (Q.14), out_row, out_col, last_of_image
//   csr_*     in         write enable only   kernel rows 0..3, four Q1.14 coefficients each
//
// One pixel is taken every clock while req_chan.ready is high; its window passes stage one, the queue and the back end.
// The line buffer RAM is read and rewritten once per pixel, one column per cycle.
// Reset is synchronous and clears the counters, valid flags and kernel; there is no clearing pass.
// A stalled result holds the arithmetic stages; the four-entry window queue absorbs the front end
// until it fills, and then req_chan.ready drops.
module conv2d_4x4_valid_stream_core #(
   parameter int IMG_SIZE = 28
) (
   input  logic                                  clock,
   input  logic                                  reset,
   c2d_stream_if.sink                            req_chan,
   c2d_stream_if.source                          rsp_chan,
   input  logic                                  csr_wr_en,
   input  logic [c2d_pkg::KREG_IDX_W-1:0]        csr_index,
   input  logic [c2d_pkg::KREG_W-1:0]            csr_wr_data
);
   import c2d_pkg::*;

   kernel_type   kernel_ff;
   q_push_type   q_push;
   q_status_type q_status;
   win_item_type q_head;
   logic         q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff <= '0;
      end else if (csr_wr_en) begin
         kernel_ff[csr_index] <= csr_wr_data;
      end
   end

   c2d_front #(
      .IMG_SIZE (IMG_SIZE)
   ) u_c2d_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_status (q_status),
      .q_push   (q_push)
   );

   c2d_queue u_c2d_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .pop      (q_pop),
      .head     (q_head),
      .q_status (q_status)
   );

   c2d_back u_c2d_back (
      .clock    (clock),
      .reset    (reset),
      .kernel   (kernel_ff),
      .head     (q_head),
      .q_status (q_status),
      .pop      (q_pop),
      .rsp_chan (rsp_chan)
   );
endmodule

>>> rtl/c2d_checker.sv
// Port-level checks for the convolution core and the bind that attaches them.
module c2d_checker #(
   parameter int IMG_SIZE = 28
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input c2d_pkg::rsp_payload_type rsp_payload
);
   import c2d_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(IMG_SIZE - KSIZE);

   // No result may appear in the cycle after reset, before any request could reach the output.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("result changed while stalled");

   // The final result of an image must be the bottom-right window.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.last_of_image |->
         rsp_payload.out_row == LAST_IDX && rsp_payload.out_col == LAST_IDX)
      else $error("end of image flagged away from the last window");

   // The request handshake and the result valid must be known whenever the core is out of reset.
   assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_valid, req_ready, rsp_valid}))
      else $error("handshake signal unknown");
endmodule

bind conv2d_4x4_valid_stream_core c2d_checker #(
   .IMG_SIZE (IMG_SIZE)
) u_c2d_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

>>> dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the 4x4 convolution core: a random pixel stream with idle gaps and result stalls.
module testbench;
   import c2d_pkg::*;

   // The image size matches the core's default configuration.
   localparam int IMG_SIZE     = 28;
   localparam int STIM_ITEMS   = 720;
   localparam int DRAIN_CYCLES = 12;
   localparam int IDLE_LIMIT   = 4000;

   localparam logic [COEF_W-1:0] COEF_MAX = 16'h7FFF;
   localparam logic [COEF_W-1:0] COEF_MIN = 16'h8000;
   localparam logic [COEF_W-1:0] COEF_ONE = 16'h4000;

   typedef enum logic [KREG_IDX_W-1:0] {
      KERNEL_ROW0, KERNEL_ROW1, KERNEL_ROW2, KERNEL_ROW3
   } kernel_reg_type;

   typedef enum int {
      KSET_MAX_POS, KSET_MAX_NEG, KSET_RANDOM, KSET_SINGLE_TAP, KSET_MIXED
   } kernel_style_type;

   typedef enum int {
      PIX_RANDOM, PIX_ALL_HIGH, PIX_ALL_LOW, PIX_EXTREMES, PIX_DIM
   } pixel_style_type;

   typedef enum int {RX_STEADY, RX_RANDOM, RX_LONG_STALL} rx_style_type;

   class conv_sum_tracker_type;
      kernel_type       kernel;
      logic [PIX_W-1:0] line_buf [LINES][IMG_SIZE];
      logic [PIX_W-1:0] win [KSIZE][KSIZE];
      int               row_pos;
      int               col_pos;
      rsp_payload_type  pending_sums[$];
      int               pixels_seen;
      int               sums_checked;
      int               images_done;
      int               mismatches;

      function void clear();
         kernel = '0;
         foreach (line_buf[m, c]) line_buf[m][c] = '0;
         foreach (win[m, n]) win[m][n] = '0;
         row_pos = 0;
         col_pos = 0;
         pending_sums.delete();
      endfunction

      // Shift the pixel into the window and line buffers; queue a sum once the window is full.
      function void note_pixel(logic [PIX_W-1:0] px);
         logic [PIX_W-1:0]         column [KSIZE];
         longint                   acc;
         logic signed [COEF_W-1:0] coef;
         rsp_payload_type          want;
         for (int m = 0; m < LINES; m++) column[m] = line_buf[m][col_pos];
         column[LINES] = px;
         for (int m = 0; m < KSIZE; m++) begin
            for (int n = 0; n < KSIZE - 1; n++) win[m][n] = win[m][n+1];
            win[m][KSIZE-1] = column[m];
         end
         for (int m = 0; m < LINES - 1; m++) line_buf[m][col_pos] = line_buf[m+1][col_pos];
         line_buf[LINES-1][col_pos] = px;
         if (row_pos >= LINES && col_pos >= LINES) begin
            acc = 0;
            for (int m = 0; m < KSIZE; m++) begin
               for (int n = 0; n < KSIZE; n++) begin
                  coef = kernel[m][COEF_W*n +: COEF_W];
                  acc += longint'(win[m][n]) * longint'(coef);
               end
            end
            want.conv_sum      = acc[SUM_W-1:0];
            want.out_row       = IDX_W'(row_pos - LINES);
            want.out_col       = IDX_W'(col_pos - LINES);
            want.last_of_image = (row_pos == IMG_SIZE - 1 && col_pos == IMG_SIZE - 1);
            pending_sums = {pending_sums, want};
         end
         pixels_seen++;
         col_pos++;
         if (col_pos == IMG_SIZE) begin
            col_pos = 0;
            row_pos++;
            if (row_pos == IMG_SIZE) begin
               row_pos = 0;
               images_done++;
            end
         end
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_sums.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result: sum %0d row %0d col %0d last %0b",
                        got.conv_sum, got.out_row, got.out_col, got.last_of_image);
            return;
         end
         want = pending_sums.pop_front();
         sums_checked++;
         if (got.conv_sum !== want.conv_sum || got.out_row !== want.out_row ||
             got.out_col !== want.out_col || got.last_of_image !== want.last_of_image) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Mismatch: expected sum %0d row %0d col %0d last %0b",
                        want.conv_sum, want.out_row, want.out_col, want.last_of_image);
               $display("          actual   sum %0d row %0d col %0d last %0b",
                        got.conv_sum, got.out_row, got.out_col, got.last_of_image);
            end
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [KREG_IDX_W-1:0] csr_index;
   logic [KREG_W-1:0]     csr_wr_data;

   c2d_stream_if #(.payload_type(req_payload_type)) req_if ();
   c2d_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   conv2d_4x4_valid_stream_core #(.IMG_SIZE(IMG_SIZE)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   conv_sum_tracker_type tracker = new;

   int           burst_left;
   int           kernels_used;
   int           idle_cycles;
   rx_style_type rx_style;
   int           rx_style_left;
   int           rx_run_left;
   logic         rx_level;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic kernel_type make_kernel(kernel_style_type style);
      kernel_type k;
      int         tap_m;
      int         tap_n;
      int         pick;
      tap_m = $urandom_range(KSIZE - 1);
      tap_n = $urandom_range(KSIZE - 1);
      for (int m = 0; m < KSIZE; m++) begin
         for (int n = 0; n < KSIZE; n++) begin
            pick = $urandom_range(5);
            case (style)
               KSET_MAX_POS:    k[m][COEF_W*n +: COEF_W] = COEF_MAX;
               KSET_MAX_NEG:    k[m][COEF_W*n +: COEF_W] = COEF_MIN;
               KSET_SINGLE_TAP: k[m][COEF_W*n +: COEF_W] =
                                   (m == tap_m && n == tap_n) ? COEF_ONE : '0;
               KSET_MIXED: begin
                  case (pick)
                     0:       k[m][COEF_W*n +: COEF_W] = COEF_MIN;
                     1:       k[m][COEF_W*n +: COEF_W] = COEF_MAX;
                     2:       k[m][COEF_W*n +: COEF_W] = '0;
                     3:       k[m][COEF_W*n +: COEF_W] = '1;
                     default: k[m][COEF_W*n +: COEF_W] = COEF_W'($urandom);
                  endcase
               end
               default:         k[m][COEF_W*n +: COEF_W] = COEF_W'($urandom);
            endcase
         end
      end
      return k;
   endfunction

   function automatic logic [PIX_W-1:0] next_pixel(pixel_style_type style);
      case (style)
         PIX_ALL_HIGH: return '1;
         PIX_ALL_LOW:  return '0;
         PIX_EXTREMES: return $urandom_range(1) ? '1 : '0;
         PIX_DIM:      return PIX_W'($urandom_range(15));
         default:      return PIX_W'($urandom_range(255));
      endcase
   endfunction

   // Bursts of back-to-back pixels separated by random gaps; some bursts follow with no gap.
   task push_pixel(input logic [PIX_W-1:0] px);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(24, 1);
      end
      burst_left--;
      req_if.valid         <= 1'b1;
      req_if.payload.pixel <= px;
      do @(posedge clock); while (!req_if.ready);
      tracker.note_pixel(px);
   endtask

   // Stop sending and wait until every queued sum has come out and the pipeline is empty.
   task settle();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (tracker.pending_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task write_kernel_row(input kernel_reg_type idx, input logic [KREG_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      tracker.kernel[idx] = value;
   endtask

   task program_kernel(input kernel_type k);
      write_kernel_row(KERNEL_ROW0, k[KERNEL_ROW0]);
      write_kernel_row(KERNEL_ROW1, k[KERNEL_ROW1]);
      write_kernel_row(KERNEL_ROW2, k[KERNEL_ROW2]);
      write_kernel_row(KERNEL_ROW3, k[KERNEL_ROW3]);
      csr_wr_en <= 1'b0;
      kernels_used++;
   endtask

   // Result side: check every accepted result and stall on a pattern that changes style.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready  <= 1'b0;
         rx_style      <= RX_STEADY;
         rx_style_left <= 50;
         rx_run_left   <= 0;
         rx_level      <= 1'b1;
      end else begin
         if (rsp_if.valid && rsp_if.ready) tracker.check_result(rsp_if.payload);
         if (rx_style_left == 0) begin
            rx_style      <= rx_style_type'($urandom_range(2));
            rx_style_left <= $urandom_range(200, 20);
         end else begin
            rx_style_left <= rx_style_left - 1;
         end
         case (rx_style)
            RX_STEADY: rsp_if.ready <= 1'b1;
            RX_RANDOM: rsp_if.ready <= ($urandom_range(99) < 60);
            default: begin
               if (rx_run_left == 0) begin
                  rx_level     <= ~rx_level;
                  rx_run_left  <= rx_level ? $urandom_range(12, 1) : $urandom_range(4, 1);
                  rsp_if.ready <= ~rx_level;
               end else begin
                  rx_run_left  <= rx_run_left - 1;
                  rsp_if.ready <= rx_level;
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog: nothing accepted for %0d cycles, %0d sums outstanding",
                  IDLE_LIMIT, tracker.pending_sums.size());
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int               phase;
      int               phase_len;
      int               fails;
      kernel_style_type k_style;
      pixel_style_type  pix_style;
      reset                <= 1'b1;
      csr_wr_en            <= 1'b0;
      csr_index            <= '0;
      csr_wr_data          <= '0;
      req_if.valid         <= 1'b0;
      req_if.payload       <= '0;
      burst_left           = 0;
      kernels_used         = 1;
      k_style              = KSET_RANDOM;
      pix_style            = PIX_RANDOM;
      tracker.clear();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening with the reset kernel: extremes and walking ones and zeros.
      push_pixel(8'h00);
      push_pixel(8'hFF);
      for (int b = 0; b < PIX_W; b++) begin
         push_pixel(PIX_W'(1 << b));
         push_pixel(~PIX_W'(1 << b));
      end
      push_pixel(8'h55);
      push_pixel(8'hAA);

      // Phases one and two pair extreme kernels with saturated pixels to reach both sum limits.
      for (phase = 0; tracker.pixels_seen < STIM_ITEMS; phase++) begin
         case (phase)
            0: pix_style = PIX_RANDOM;
            1: begin
               k_style   = KSET_MAX_POS;
               pix_style = PIX_ALL_HIGH;
            end
            2: begin
               k_style   = KSET_MAX_NEG;
               pix_style = PIX_ALL_HIGH;
            end
            3: begin
               k_style   = KSET_SINGLE_TAP;
               pix_style = PIX_EXTREMES;
            end
            default: begin
               k_style   = kernel_style_type'($urandom_range(4));
               pix_style = pixel_style_type'($urandom_range(4));
            end
         endcase
         if (phase != 0) begin
            settle();
            program_kernel(make_kernel(k_style));
         end
         phase_len = (phase < 4) ? 60 : $urandom_range(110, 25);
         repeat (phase_len) push_pixel(next_pixel(pix_style));
      end

      settle();
      fails = tracker.mismatches + tracker.pending_sums.size();
      $display("Streamed %0d pixels, %0d complete %0dx%0d images; %0d sums compared.",
               tracker.pixels_seen, tracker.images_done, IMG_SIZE, IMG_SIZE,
               tracker.sums_checked);
      $display("Used %0d kernel settings under sender gaps and result stalls; %0d errors.",
               kernels_used, fails);
      if (fails == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
